@@ design/lds_pkg.sv @@
// ----------------------------------------------------------------------------
// lds_pkg
// Types, widths and helpers shared by the diffuse shading pipeline.
// ----------------------------------------------------------------------------
package lds_pkg;

	localparam int COS_BITS   = 30;
	localparam int RATIO_BITS = 16;
	localparam int SQ_W       = 68;   // squared length, padded to 2*ROOT_W
	localparam int ROOT_W     = 34;
	localparam int REM_W      = 38;
	localparam int DOT_W      = 67;
	localparam int MAG_W      = 65;   // positive dot product
	localparam int NUM_W      = 96;
	localparam int DEN_W      = 68;
	localparam int Q_W        = 41;
	localparam int CMP_W      = 110;
	localparam int QS_W       = 31;
	localparam int CR_W       = 25;
	localparam int P_W        = 56;
	localparam int ADDR_W     = 5;

	localparam logic [2:0] REG_LX    = 3'd0;
	localparam logic [2:0] REG_LY    = 3'd1;
	localparam logic [2:0] REG_LZ    = 3'd2;
	localparam logic [2:0] REG_RED   = 3'd3;
	localparam logic [2:0] REG_GREEN = 3'd4;
	localparam logic [2:0] REG_BLUE  = 3'd5;
	localparam logic [2:0] REG_RATIO = 3'd6;

	localparam logic [QS_W-1:0] COS_ONE = QS_W'(1) << COS_BITS;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [16:0] ratio;
	} light_t;

	typedef struct packed {
		logic [31:0] hit_x;
		logic [31:0] hit_y;
		logic [31:0] hit_z;
		logic [31:0] normal_x;
		logic [31:0] normal_y;
		logic [31:0] normal_z;
		logic [7:0]  object_red;
		logic [7:0]  object_green;
		logic [7:0]  object_blue;
	} hit_t;

	typedef struct packed {
		logic             zero;
		logic [MAG_W-1:0] dot;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
	} side_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_t;

	// one restoring square-root digit
	function automatic sqrt_t sqrt_step(sqrt_t a, logic [1:0] bits);
		logic [REM_W-1:0] r;
		logic [REM_W-1:0] t;
		sqrt_t            o;
		r = {a.rem[REM_W-3:0], bits};
		t = {{(REM_W-ROOT_W-2){1'b0}}, a.root, 2'b01};
		if (r >= t) begin
			o.rem  = r - t;
			o.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			o.rem  = r;
			o.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		return o;
	endfunction

endpackage

@@ design/lds_intf.sv @@
// ----------------------------------------------------------------------------
// lds channel interfaces
// Hit input channel and shade result channel, valid/ready.
// ----------------------------------------------------------------------------
interface hit_if;
	logic        valid;
	logic        ready;
	logic [31:0] hit_x;
	logic [31:0] hit_y;
	logic [31:0] hit_z;
	logic [31:0] normal_x;
	logic [31:0] normal_y;
	logic [31:0] normal_z;
	logic [7:0]  object_red;
	logic [7:0]  object_green;
	logic [7:0]  object_blue;
	modport source (output valid, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z,
		object_red, object_green, object_blue, input ready);
	modport sink (input valid, hit_x, hit_y, hit_z, normal_x, normal_y, normal_z,
		object_red, object_green, object_blue, output ready);
endinterface

interface shade_if;
	logic       valid;
	logic       ready;
	logic [7:0] shade_red;
	logic [7:0] shade_green;
	logic [7:0] shade_blue;
	modport source (output valid, shade_red, shade_green, shade_blue, input ready);
	modport sink (input valid, shade_red, shade_green, shade_blue, output ready);
endinterface

@@ design/lds_front.sv @@
// ----------------------------------------------------------------------------
// lds_front
// Light vector, products and sums: dot(d,n), |d|^2, |n|^2. Three stages.
// ----------------------------------------------------------------------------
module lds_front import lds_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  hit_t            hit,
	input  light_t          light,
	output logic            out_valid,
	output logic [SQ_W-1:0] dd,
	output logic [SQ_W-1:0] nn,
	output side_t           side
);

	logic               v_s1, v_s2, v_s3;
	logic signed [32:0] d_s1 [3];
	logic signed [31:0] n_s1 [3];
	logic [23:0]        obj_s1, obj_s2;
	logic signed [64:0] pdn_s2 [3];
	logic [64:0]        sqd_s2 [3];
	logic [62:0]        sqn_s2 [3];
	logic signed [64:0] pdn [3];
	logic signed [65:0] sqd [3];
	logic signed [63:0] sqn [3];
	logic signed [DOT_W-1:0] dot;
	logic [SQ_W-1:0]    dd_sum, nn_sum;
	logic [SQ_W-1:0]    dd_s3, nn_s3;
	side_t              side_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pdn[i] = 65'(d_s1[i]) * 65'(n_s1[i]);
			sqd[i] = 66'(d_s1[i]) * 66'(d_s1[i]);
			sqn[i] = 64'(n_s1[i]) * 64'(n_s1[i]);
		end
		dot = {{2{pdn_s2[0][64]}}, pdn_s2[0]} + {{2{pdn_s2[1][64]}}, pdn_s2[1]}
			+ {{2{pdn_s2[2][64]}}, pdn_s2[2]};
		dd_sum = SQ_W'(sqd_s2[0]) + SQ_W'(sqd_s2[1]) + SQ_W'(sqd_s2[2]);
		nn_sum = SQ_W'(sqn_s2[0]) + SQ_W'(sqn_s2[1]) + SQ_W'(sqn_s2[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= $signed({light.x[31], light.x}) - $signed({hit.hit_x[31], hit.hit_x});
			d_s1[1] <= $signed({light.y[31], light.y}) - $signed({hit.hit_y[31], hit.hit_y});
			d_s1[2] <= $signed({light.z[31], light.z}) - $signed({hit.hit_z[31], hit.hit_z});
			n_s1[0] <= $signed(hit.normal_x);
			n_s1[1] <= $signed(hit.normal_y);
			n_s1[2] <= $signed(hit.normal_z);
			obj_s1  <= {hit.object_red, hit.object_green, hit.object_blue};
			for (int i = 0; i < 3; i++) begin
				pdn_s2[i] <= pdn[i];
				sqd_s2[i] <= sqd[i][64:0];
				sqn_s2[i] <= sqn[i][62:0];
			end
			obj_s2        <= obj_s1;
			dd_s3         <= dd_sum;
			nn_s3         <= nn_sum;
			side_s3.zero  <= dot[DOT_W-1] || (dot == '0) || (dd_sum == '0) || (nn_sum == '0);
			side_s3.dot   <= dot[MAG_W-1:0];
			side_s3.red   <= obj_s2[23:16];
			side_s3.green <= obj_s2[15:8];
			side_s3.blue  <= obj_s2[7:0];
		end
	end

	assign out_valid = v_s3;
	assign dd        = dd_s3;
	assign nn        = nn_s3;
	assign side      = side_s3;

endmodule

@@ design/lds_sqrt.sv @@
// ----------------------------------------------------------------------------
// lds_sqrt
// Two floor square roots in parallel, one result bit per stage.
// ----------------------------------------------------------------------------
module lds_sqrt import lds_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [SQ_W-1:0]   dd,
	input  logic [SQ_W-1:0]   nn,
	input  side_t             side_in,
	output logic              out_valid,
	output logic [ROOT_W-1:0] ld,
	output logic [ROOT_W-1:0] ln,
	output side_t             side_out
);

	logic            v_s    [ROOT_W+1];
	logic [SQ_W-1:0] dd_s   [ROOT_W+1];
	logic [SQ_W-1:0] nn_s   [ROOT_W+1];
	sqrt_t           sd_s   [ROOT_W+1];
	sqrt_t           sn_s   [ROOT_W+1];
	side_t           side_s [ROOT_W+1];

	assign v_s[0]    = in_valid;
	assign dd_s[0]   = dd;
	assign nn_s[0]   = nn;
	assign sd_s[0]   = '0;
	assign sn_s[0]   = '0;
	assign side_s[0] = side_in;

	for (genvar k = 1; k <= ROOT_W; k++) begin : g_stage
		localparam int B = 2 * (ROOT_W - k);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dd_s[k]   <= dd_s[k-1];
				nn_s[k]   <= nn_s[k-1];
				sd_s[k]   <= sqrt_step(sd_s[k-1], dd_s[k-1][B+1:B]);
				sn_s[k]   <= sqrt_step(sn_s[k-1], nn_s[k-1][B+1:B]);
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = v_s[ROOT_W];
	assign ld        = sd_s[ROOT_W].root;
	assign ln        = sn_s[ROOT_W].root;
	assign side_out  = side_s[ROOT_W];

endmodule

@@ design/lds_div.sv @@
// ----------------------------------------------------------------------------
// lds_div
// Cosine quotient dot*2^30 / (|d|*|n|), restoring, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lds_div import lds_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [ROOT_W-1:0] ld,
	input  logic [ROOT_W-1:0] ln,
	input  side_t             side_in,
	output logic              out_valid,
	output logic [Q_W-1:0]    q,
	output side_t             side_out
);

	logic             v_s    [Q_W+1];
	logic [DEN_W-1:0] den_s  [Q_W+1];
	logic [NUM_W-1:0] rem_s  [Q_W+1];
	logic [Q_W-1:0]   q_s    [Q_W+1];
	side_t            side_s [Q_W+1];
	logic [DEN_W-1:0] prod;

	assign prod = DEN_W'(ld) * DEN_W'(ln);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0]  <= prod;
			rem_s[0]  <= NUM_W'({side_in.dot, {COS_BITS{1'b0}}});
			q_s[0]    <= '0;
			side_s[0] <= side_in;
		end
	end

	for (genvar j = 1; j <= Q_W; j++) begin : g_stage
		localparam int SH = Q_W - j;
		logic [CMP_W-1:0] t;
		logic [CMP_W-1:0] r;
		assign t = CMP_W'(den_s[j-1]) << SH;
		assign r = CMP_W'(rem_s[j-1]);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_s[j-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j]  <= den_s[j-1];
				side_s[j] <= side_s[j-1];
				if (t <= r) begin
					rem_s[j] <= NUM_W'(r - t);
					q_s[j]   <= q_s[j-1] | (Q_W'(1) << SH);
				end else begin
					rem_s[j] <= rem_s[j-1];
					q_s[j]   <= q_s[j-1];
				end
			end
		end
	end

	assign out_valid = v_s[Q_W];
	assign q         = q_s[Q_W];
	assign side_out  = side_s[Q_W];

endmodule

@@ design/lds_back.sv @@
// ----------------------------------------------------------------------------
// lds_back
// Cosine saturation, light scaling and clamp to the object colour.
// ----------------------------------------------------------------------------
module lds_back import lds_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [Q_W-1:0] q,
	input  side_t          side_in,
	input  light_t         light,
	output logic           out_valid,
	output logic [7:0]     red,
	output logic [7:0]     green,
	output logic [7:0]     blue
);

	logic            v_s1, v_s2, v_s3;
	logic [QS_W-1:0] qs_s1;
	logic [CR_W-1:0] cr_s1 [3];
	side_t           side_s1, side_s2;
	logic [P_W-1:0]  p_s2 [3];
	logic [7:0]      ch_s3 [3];
	logic [7:0]      obj [3];
	logic [9:0]      pw [3];

	assign obj[0] = side_s2.red;
	assign obj[1] = side_s2.green;
	assign obj[2] = side_s2.blue;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pw[i] = p_s2[i][P_W-1:RATIO_BITS+COS_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qs_s1    <= (q > Q_W'(COS_ONE)) ? COS_ONE : q[QS_W-1:0];
			cr_s1[0] <= CR_W'(light.red) * CR_W'(light.ratio);
			cr_s1[1] <= CR_W'(light.green) * CR_W'(light.ratio);
			cr_s1[2] <= CR_W'(light.blue) * CR_W'(light.ratio);
			side_s1  <= side_in;
			for (int i = 0; i < 3; i++) begin
				p_s2[i] <= P_W'(cr_s1[i]) * P_W'(qs_s1);
			end
			side_s2 <= side_s1;
			for (int i = 0; i < 3; i++) begin
				if (side_s2.zero) begin
					ch_s3[i] <= '0;
				end else if (pw[i] < 10'(obj[i])) begin
					ch_s3[i] <= pw[i][7:0];
				end else begin
					ch_s3[i] <= obj[i];
				end
			end
		end
	end

	assign out_valid = v_s3;
	assign red       = ch_s3[0];
	assign green     = ch_s3[1];
	assign blue      = ch_s3[2];

`ifndef SYNTHESIS
	a_cos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(en && in_valid) |=> (qs_s1 <= COS_ONE))
		else $error("cosine above one after saturation");
	a_zero_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s2 && side_s2.zero) |=> (red == '0 && green == '0 && blue == '0))
		else $error("shade not dark for a back-facing or degenerate hit");
	a_obj_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s2 && side_s2.red == '0) |=> (red == '0))
		else $error("red exceeds object colour");
`endif

endmodule

@@ design/lambert_diffuse_shade_top.sv @@
// ----------------------------------------------------------------------------
// lambert_diffuse_shade_top
// Lambertian diffuse shading of ray hits against one point light.
// ----------------------------------------------------------------------------
// Usage:
//   hit_in carries one hit per transfer: point, normal of any length and
//   object colour. shade_out carries one shaded colour per hit, in order.
//   The light position, colour and ratio are set through the APB port
//   (register i at byte address 4*i); write them only while no hit is in
//   flight.
//   The pipeline has 3 front stages, 34 square-root stages (one root bit
//   each), 1 + 41 divider stages (one quotient bit each) and 3 back stages.
//   Throughput is one hit per cycle while shade_out takes every result.
//   The whole pipeline advances together; when shade_out holds a result
//   that is not taken, every stage holds and hit_in.ready drops, so nothing
//   is lost or repeated.
//   Reset empties the pipeline, puts the light at the origin, colour white
//   and ratio 1.0.
// ----------------------------------------------------------------------------
module lambert_diffuse_shade_top import lds_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	hit_if.sink               hit_in,
	shade_if.source           shade_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	light_t            light_q;
	hit_t              hit;
	logic              en;
	logic              wr;
	logic [2:0]        idx;
	logic              f_valid, s_valid, d_valid, b_valid;
	logic [SQ_W-1:0]   dd, nn;
	side_t             f_side, s_side, d_side;
	logic [ROOT_W-1:0] ld, ln;
	logic [Q_W-1:0]    q;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q.x     <= '0;
			light_q.y     <= '0;
			light_q.z     <= '0;
			light_q.red   <= 8'd255;
			light_q.green <= 8'd255;
			light_q.blue  <= 8'd255;
			light_q.ratio <= 17'd65536;
		end else if (wr) begin
			unique case (idx)
				REG_LX:    light_q.x     <= pwdata;
				REG_LY:    light_q.y     <= pwdata;
				REG_LZ:    light_q.z     <= pwdata;
				REG_RED:   light_q.red   <= pwdata[7:0];
				REG_GREEN: light_q.green <= pwdata[7:0];
				REG_BLUE:  light_q.blue  <= pwdata[7:0];
				REG_RATIO: light_q.ratio <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LX:    prdata = light_q.x;
			REG_LY:    prdata = light_q.y;
			REG_LZ:    prdata = light_q.z;
			REG_RED:   prdata = 32'(light_q.red);
			REG_GREEN: prdata = 32'(light_q.green);
			REG_BLUE:  prdata = 32'(light_q.blue);
			REG_RATIO: prdata = 32'(light_q.ratio);
			default:   prdata = '0;
		endcase
	end

	// global advance: the output register is the last stage
	assign en           = !b_valid || shade_out.ready;
	assign hit_in.ready = en;

	assign hit.hit_x        = hit_in.hit_x;
	assign hit.hit_y        = hit_in.hit_y;
	assign hit.hit_z        = hit_in.hit_z;
	assign hit.normal_x     = hit_in.normal_x;
	assign hit.normal_y     = hit_in.normal_y;
	assign hit.normal_z     = hit_in.normal_z;
	assign hit.object_red   = hit_in.object_red;
	assign hit.object_green = hit_in.object_green;
	assign hit.object_blue  = hit_in.object_blue;

	lds_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(hit_in.valid), .hit(hit),
		.light(light_q), .out_valid(f_valid), .dd(dd), .nn(nn), .side(f_side)
	);

	lds_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(f_valid), .dd(dd), .nn(nn),
		.side_in(f_side), .out_valid(s_valid), .ld(ld), .ln(ln), .side_out(s_side)
	);

	lds_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(s_valid), .ld(ld), .ln(ln),
		.side_in(s_side), .out_valid(d_valid), .q(q), .side_out(d_side)
	);

	lds_back u_back (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(d_valid), .q(q),
		.side_in(d_side), .light(light_q), .out_valid(b_valid),
		.red(shade_out.shade_red), .green(shade_out.shade_green),
		.blue(shade_out.shade_blue)
	);

	assign shade_out.valid = b_valid;

endmodule

@@ sim/lambert_diffuse_shade_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lambert_diffuse_shade_top_test
// Drives hits through the diffuse shading pipeline under random idling and
// back-pressure, and checks every shaded colour against an in-bench predictor
// of the Lambert cosine. Light registers are rewritten over several phases.
// ----------------------------------------------------------------------------
module lambert_diffuse_shade_top_test;
	import lds_pkg::*;

	localparam int SETTLE_CYCLES = 100;
	localparam int STALL_LIMIT   = 5000;
	localparam int RAND_ITEMS    = 1300;
	localparam int N_DIRECTED    = 18;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} shade_t;

	typedef struct {
		hit_t   hit;
		logic   known;
		shade_t want;
	} hit_row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	hit_if   hit_ch();
	shade_if shade_ch();

	lambert_diffuse_shade_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.hit_in   (hit_ch.sink),
		.shade_out(shade_ch.source),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	light_t light;
	shade_t shade_q[$];
	int     errors;
	int     stall_cycles;
	bit     sink_hold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// floor square root of a value below 2^68
	function automatic logic [ROOT_W-1:0] root_floor(logic [SQ_W-1:0] v);
		logic [ROOT_W-1:0] r;
		logic [ROOT_W-1:0] c;
		r = '0;
		for (int b = ROOT_W - 1; b >= 0; b--) begin
			c = r | (ROOT_W'(1) << b);
			if ((SQ_W'(c) * SQ_W'(c)) <= v) r = c;
		end
		return r;
	endfunction

	function automatic shade_t lambert_shade(light_t lt, hit_t h);
		logic signed [33:0] d [3];
		logic signed [33:0] n [3];
		logic signed [DOT_W+1:0] dot;
		logic [SQ_W-1:0] dd, nn;
		logic [ROOT_W-1:0] ld, ln;
		logic [CMP_W-1:0] num, den, q;
		logic [P_W+30:0] p;
		logic [7:0] lch [3];
		logic [7:0] och [3];
		logic [7:0] res [3];
		shade_t s;
		d[0] = $signed({lt.x[31], lt.x}) - $signed({h.hit_x[31], h.hit_x});
		d[1] = $signed({lt.y[31], lt.y}) - $signed({h.hit_y[31], h.hit_y});
		d[2] = $signed({lt.z[31], lt.z}) - $signed({h.hit_z[31], h.hit_z});
		n[0] = $signed(h.normal_x);
		n[1] = $signed(h.normal_y);
		n[2] = $signed(h.normal_z);
		dot = '0;
		dd  = '0;
		nn  = '0;
		for (int i = 0; i < 3; i++) begin
			dot += (DOT_W+2)'(d[i]) * (DOT_W+2)'(n[i]);
			dd  += SQ_W'(d[i]) * SQ_W'(d[i]);
			nn  += SQ_W'(n[i]) * SQ_W'(n[i]);
		end
		s = '0;
		if (dot <= 0) return s;
		ld = root_floor(dd);
		ln = root_floor(nn);
		if (ld == 0 || ln == 0) return s;
		num = CMP_W'(dot) << COS_BITS;
		den = CMP_W'(ld) * CMP_W'(ln);
		q = num / den;
		if (q > (CMP_W'(1) << COS_BITS)) q = CMP_W'(1) << COS_BITS;
		lch = '{lt.red, lt.green, lt.blue};
		och = '{h.object_red, h.object_green, h.object_blue};
		for (int i = 0; i < 3; i++) begin
			p = ((P_W+31)'(lch[i]) * (P_W+31)'(lt.ratio) * (P_W+31)'(q))
				>> (RATIO_BITS + COS_BITS);
			res[i] = (p < (P_W+31)'(och[i])) ? p[7:0] : och[i];
		end
		s.red   = res[0];
		s.green = res[1];
		s.blue  = res[2];
		return s;
	endfunction

	task automatic write_light_reg(logic [2:0] idx, logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_LX:    light.x     = value;
			REG_LY:    light.y     = value;
			REG_LZ:    light.z     = value;
			REG_RED:   light.red   = value[7:0];
			REG_GREEN: light.green = value[7:0];
			REG_BLUE:  light.blue  = value[7:0];
			REG_RATIO: light.ratio = value[16:0];
			default: ;
		endcase
	endtask

	task automatic set_light(light_t lt);
		write_light_reg(REG_LX, lt.x);
		write_light_reg(REG_LY, lt.y);
		write_light_reg(REG_LZ, lt.z);
		write_light_reg(REG_RED, 32'(lt.red));
		write_light_reg(REG_GREEN, 32'(lt.green));
		write_light_reg(REG_BLUE, 32'(lt.blue));
		write_light_reg(REG_RATIO, 32'(lt.ratio));
	endtask

	// sends one hit, inputs driven at the falling edge, transfer seen at rising
	task automatic send_hit(hit_t h, logic known, shade_t want);
		hit_ch.valid        <= 1'b1;
		hit_ch.hit_x        <= h.hit_x;
		hit_ch.hit_y        <= h.hit_y;
		hit_ch.hit_z        <= h.hit_z;
		hit_ch.normal_x     <= h.normal_x;
		hit_ch.normal_y     <= h.normal_y;
		hit_ch.normal_z     <= h.normal_z;
		hit_ch.object_red   <= h.object_red;
		hit_ch.object_green <= h.object_green;
		hit_ch.object_blue  <= h.object_blue;
		do @(posedge clk); while (!hit_ch.ready);
		if (known) shade_q.push_back(want);
		else shade_q.push_back(lambert_shade(light, h));
		@(negedge clk);
	endtask

	task automatic idle_gap(int n);
		hit_ch.valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		while (shade_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 40000)) - 20000) <<< 8;
			default: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
		endcase
	endfunction

	function automatic hit_t rand_hit();
		hit_t h;
		int m;
		m = $urandom_range(0, 2);
		h.hit_x        = rand_coord(m);
		h.hit_y        = rand_coord(m);
		h.hit_z        = rand_coord(m);
		h.normal_x     = rand_coord($urandom_range(0, 2));
		h.normal_y     = rand_coord($urandom_range(0, 2));
		h.normal_z     = rand_coord($urandom_range(0, 2));
		if ($urandom_range(0, 15) == 0) h.normal_x = '0;
		h.object_red   = $urandom();
		h.object_green = $urandom();
		h.object_blue  = $urandom();
		return h;
	endfunction

	function automatic light_t rand_light();
		light_t lt;
		lt.x     = rand_coord($urandom_range(0, 2));
		lt.y     = rand_coord($urandom_range(0, 2));
		lt.z     = rand_coord($urandom_range(0, 2));
		lt.red   = $urandom();
		lt.green = $urandom();
		lt.blue  = $urandom();
		lt.ratio = $urandom_range(0, 3) == 0 ? 17'h1ffff : 17'($urandom_range(0, 65536));
		return lt;
	endfunction

	// receiver stalls: alternating runs of ready and stall
	initial begin
		int run;
		shade_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			sink_hold = ~sink_hold;
			run = sink_hold ? $urandom_range(0, 6) : $urandom_range(1, 40);
			if ($urandom_range(0, 7) == 0 && sink_hold) run = 0;
			repeat (run) begin
				@(negedge clk);
				shade_ch.ready <= !sink_hold;
			end
		end
	end

	always @(posedge clk) begin
		shade_t got;
		shade_t want;
		if (arst_n && shade_ch.valid && shade_ch.ready) begin
			got = '{shade_ch.shade_red, shade_ch.shade_green, shade_ch.shade_blue};
			if (shade_q.size() == 0) begin
				$display("%0t: unexpected shade %h", $realtime, got);
				errors++;
			end else begin
				want = shade_q.pop_front();
				if (got.red !== want.red)
					$display("%0t: red expected %0d actual %0d", $realtime, want.red, got.red);
				if (got.green !== want.green)
					$display("%0t: green expected %0d actual %0d", $realtime, want.green,
						got.green);
				if (got.blue !== want.blue)
					$display("%0t: blue expected %0d actual %0d", $realtime, want.blue,
						got.blue);
				if (got !== want) errors++;
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((hit_ch.valid && hit_ch.ready) || (shade_ch.valid && shade_ch.ready))
			stall_cycles = 0;
		else if (++stall_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	hit_row_t dir_rows [N_DIRECTED];

	initial begin
		light_t lt;
		hit_t   h;
		int     sent;
		int     burst;
		errors       = 0;
		stall_cycles = 0;
		sink_hold    = 1'b1;
		arst_n       = 1'b0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		hit_ch.valid = 0;
		hit_ch.hit_x = 0; hit_ch.hit_y = 0; hit_ch.hit_z = 0;
		hit_ch.normal_x = 0; hit_ch.normal_y = 0; hit_ch.normal_z = 0;
		hit_ch.object_red = 0; hit_ch.object_green = 0; hit_ch.object_blue = 0;
		light = '{x: 0, y: 0, z: 0, red: 255, green: 255, blue: 255, ratio: 17'd65536};

		// after reset light sits at origin, white, ratio 1.0
		dir_rows[0]  = '{'{32'h0, 32'h0, -32'sh10000, 32'h0, 32'h0, 32'h10000, 8'd200,
			8'd100, 8'd255}, 1'b1, '{8'd200, 8'd100, 8'd255}};
		dir_rows[1]  = '{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h10000, 8'd255, 8'd255,
			8'd255}, 1'b1, '{8'd0, 8'd0, 8'd0}};   // light at hit point
		dir_rows[2]  = '{'{32'h0, 32'h0, -32'sh10000, 32'h0, 32'h0, 32'h0, 8'd255, 8'd255,
			8'd255}, 1'b1, '{8'd0, 8'd0, 8'd0}};   // zero normal
		dir_rows[3]  = '{'{32'h0, 32'h0, -32'sh10000, 32'h0, 32'h0, -32'sh10000, 8'd255,
			8'd255, 8'd255}, 1'b1, '{8'd0, 8'd0, 8'd0}};   // facing away
		dir_rows[4]  = '{'{32'h0, 32'h0, -32'sh10000, 32'h10000, 32'h0, 32'h0, 8'd255,
			8'd255, 8'd255}, 1'b1, '{8'd0, 8'd0, 8'd0}};   // grazing, dot zero
		dir_rows[5]  = '{'{32'h0, 32'h0, -32'sh10000, 32'h0, 32'h0, 32'h10000, 8'd0, 8'd0,
			8'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}};
		dir_rows[6]  = '{'{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 8'hff, 8'hff, 8'hff}, 1'b0, '0};
		dir_rows[7]  = '{'{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
			32'h80000000, 32'h80000000, 8'hff, 8'hff, 8'hff}, 1'b0, '0};
		dir_rows[8]  = '{'{32'h80000000, 32'h0, 32'h7fffffff, 32'h7fffffff, 32'h1,
			32'h80000000, 8'h55, 8'haa, 8'h80}, 1'b0, '0};
		dir_rows[9]  = '{'{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h1, 32'h1, 32'h1,
			8'hff, 8'hff, 8'hff}, 1'b0, '0};
		dir_rows[10] = '{'{32'h0, 32'h0, -32'sh30000, 32'h1, 32'h1, 32'h7fffffff, 8'h7f,
			8'hfe, 8'h01}, 1'b0, '0};
		dir_rows[11] = '{'{32'h12345, -32'sh54321, 32'h0, 32'h3, 32'h4, 32'h0, 8'hff,
			8'hff, 8'hff}, 1'b0, '0};
		dir_rows[12] = '{'{-32'sh10000, -32'sh10000, -32'sh10000, 32'h10000, 32'h10000,
			32'h10000, 8'hff, 8'hff, 8'hff}, 1'b0, '0};   // cosine near one
		dir_rows[13] = '{'{32'h1, 32'h0, 32'h0, -32'sh1, 32'h0, 32'h0, 8'hff, 8'hff,
			8'hff}, 1'b0, '0};
		dir_rows[14] = '{'{-32'sh3, -32'sh4, 32'h0, 32'h3, 32'h4, 32'h0, 8'hff, 8'hff,
			8'hff}, 1'b0, '0};
		dir_rows[15] = '{'{32'h7fffffff, 32'h0, 32'h0, 32'h80000000, 32'h0, 32'h0, 8'hff,
			8'h0, 8'h80}, 1'b0, '0};
		dir_rows[16] = '{'{32'h0, 32'h0, 32'h80000000, 32'h0, 32'h0, 32'h7fffffff, 8'hc3,
			8'h3c, 8'hff}, 1'b0, '0};
		dir_rows[17] = '{'{32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f, 32'haaaaaaaa,
			32'h55555555, 32'hf0f0f0f0, 8'hff, 8'hff, 8'hff}, 1'b0, '0};

		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			send_hit(dir_rows[i].hit, dir_rows[i].known, dir_rows[i].want);
			if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 3));
		end
		idle_gap(0);
		drain();

		// extreme settings: ratio above one with far light corner, then ratio zero
		lt = '{x: 32'h7fffffff, y: 32'h80000000, z: 32'h0, red: 0, green: 255, blue: 1,
			ratio: 17'h1ffff};
		set_light(lt);
		for (int i = 0; i < 6; i++) send_hit(dir_rows[6 + i].hit, 1'b0, '0);
		idle_gap(0);
		drain();
		lt.ratio = '0;
		set_light(lt);
		for (int i = 0; i < 6; i++) send_hit(dir_rows[12 + i].hit, 1'b0, '0);
		idle_gap(0);
		drain();

		sent = 0;
		while (sent < RAND_ITEMS) begin
			if (sent % 260 == 0) begin
				idle_gap(0);
				drain();
				set_light(rand_light());
			end
			burst = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 20);
			for (int b = 0; b < burst && sent < RAND_ITEMS; b++) begin
				h = rand_hit();
				send_hit(h, 1'b0, '0);
				sent++;
			end
			if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
		end
		idle_gap(0);
		drain();

		if (errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule
